// ----- src/fbfl_pkg.sv -----
package fbfl_pkg;

  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] release_slot;
  } req_t;

  typedef struct packed {
    logic [7:0]  granted_slot;
    logic [15:0] byte_offset;
    logic        success;
    logic [8:0]  slots_free;
  } rsp_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear_en;
    logic release_en;
    logic alloc_start;
    logic alloc_fail;
    logic alloc_finish;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic head_valid;
    logic clear_last;
  } ctl_sts_t;

  localparam logic [8:0] ELEMENT_BYTES_RESET = 9'd8;
  localparam logic [8:0] ELEMENT_BYTES_MAX   = 9'd256;
  localparam logic [8:0] ALIGN_BYTES         = 9'd8;

endpackage

// ----- src/fbfl_ctrl.sv -----
module fbfl_ctrl
  import fbfl_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  cmd_t     req_cmd,
  output logic     req_stall,
  output logic     rsp_valid,
  input  logic     rsp_stall,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_CLEAR = 3'b001,
    ST_IDLE  = 3'b010,
    ST_ALLOC = 3'b100
  } state_t;

  state_t state, state_next;
  logic   rsp_valid_next;
  logic   accept;
  logic   rsp_load;

  // An item is taken only when the result register is free or empties this cycle.
  assign req_stall = (state != ST_IDLE) || (rsp_valid && rsp_stall);
  assign accept    = req_valid && !req_stall;

  always_comb begin
    cmd              = '0;
    cmd.clear_en     = (state == ST_CLEAR);
    cmd.release_en   = accept && (req_cmd == CMD_RELEASE);
    cmd.alloc_start  = accept && (req_cmd == CMD_ALLOC) && sts.head_valid;
    cmd.alloc_fail   = accept && (req_cmd == CMD_ALLOC) && !sts.head_valid;
    cmd.alloc_finish = (state == ST_ALLOC);
  end

  assign rsp_load = cmd.release_en || cmd.alloc_fail || cmd.alloc_finish;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (sts.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (cmd.alloc_start) state_next = ST_ALLOC;
      end
      ST_ALLOC: begin
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    rsp_valid_next = rsp_valid;
    if (rsp_load) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

endmodule

// ----- src/fbfl_dpath.sv -----
module fbfl_dpath
  import fbfl_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [8:0] cfg_data,
  input  req_t       req,
  input  ctl_cmd_t   cmd,
  output ctl_sts_t   sts,
  output rsp_t       rsp
);

  localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  // Each link entry holds a valid bit above the slot index.
  logic [SW:0]   mem [CAPACITY];
  logic [SW:0]   rd_data;

  logic [SW-1:0] head;
  logic          head_valid;
  logic [CW-1:0] free_cnt;
  logic [8:0]    element_bytes;
  logic [SW-1:0] grant;
  logic [SW-1:0] clr_idx;

  logic [SW:0]      clr_inc;
  logic             in_range;
  logic [SW+7:0]    rel_wide;
  logic [SW-1:0]    rel_idx;
  logic [CW-1:0]    cnt_inc;
  logic [CW-1:0]    cnt_dec;
  logic [8:0]       size_clamped;
  logic [8:0]       size_sum;
  logic [5:0]       size_units;
  logic [SW+5:0]    prod;
  logic [SW+24:0]   offset_wide;
  logic [SW+7:0]    grant_wide;
  logic [CW+8:0]    cnt_inc_wide;
  logic [CW+8:0]    cnt_dec_wide;
  logic [CW+8:0]    cnt_wide;
  logic             wr_en;
  logic [SW-1:0]    wr_addr;
  logic [SW:0]      wr_data;
  logic             do_release;

  assign rel_wide   = {{SW{1'b0}}, req.release_slot};
  assign rel_idx    = rel_wide[SW-1:0];
  assign in_range   = {{CW{1'b0}}, req.release_slot} < (CW + 8)'(CAPACITY);
  assign do_release = cmd.release_en && in_range;

  assign clr_inc = {1'b0, clr_idx} + 1'b1;

  assign cnt_inc = (free_cnt < CW'(CAPACITY)) ? free_cnt + 1'b1 : free_cnt;
  assign cnt_dec = (free_cnt != '0) ? free_cnt - 1'b1 : free_cnt;

  // Element size clamped to 8..256 and counted in 8-byte units.
  always_comb begin
    size_clamped = element_bytes;
    if (size_clamped > ELEMENT_BYTES_MAX) size_clamped = ELEMENT_BYTES_MAX;
    if (size_clamped < ALIGN_BYTES) size_clamped = ALIGN_BYTES;
    size_sum   = size_clamped + (ALIGN_BYTES - 9'd1);
    size_units = size_sum[8:3];
  end

  assign prod         = (SW + 6)'(grant) * (SW + 6)'(size_units);
  assign offset_wide  = {16'b0, prod, 3'b000};
  assign grant_wide   = {8'b0, grant};
  assign cnt_inc_wide = {9'b0, cnt_inc};
  assign cnt_dec_wide = {9'b0, cnt_dec};
  assign cnt_wide     = {9'b0, free_cnt};

  assign sts.head_valid = head_valid;
  assign sts.clear_last = (clr_idx == SW'(CAPACITY - 1));

  // One write port, shared by the clearing pass and releases.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = rel_idx;
    wr_data = {head_valid, head};
    if (cmd.clear_en) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx;
      wr_data = {clr_inc < (SW + 1)'(CAPACITY), clr_inc[SW-1:0]};
    end else if (do_release) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_start) rd_data <= mem[head];
  end

  always_ff @(posedge clk) begin
    if (cmd.alloc_start) grant <= head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head          <= '0;
      head_valid    <= 1'b1;
      free_cnt      <= CW'(CAPACITY);
      element_bytes <= ELEMENT_BYTES_RESET;
      clr_idx       <= '0;
    end else begin
      if (cfg_write) element_bytes <= cfg_data;
      if (cmd.clear_en) clr_idx <= clr_inc[SW-1:0];
      if (do_release) begin
        head       <= rel_idx;
        head_valid <= 1'b1;
        free_cnt   <= cnt_inc;
      end else if (cmd.alloc_finish) begin
        head       <= rd_data[SW-1:0];
        head_valid <= rd_data[SW];
        free_cnt   <= cnt_dec;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.release_en) begin
      rsp.granted_slot <= '0;
      rsp.byte_offset  <= '0;
      rsp.success      <= in_range;
      rsp.slots_free   <= in_range ? cnt_inc_wide[8:0] : cnt_wide[8:0];
    end else if (cmd.alloc_fail) begin
      rsp.granted_slot <= '0;
      rsp.byte_offset  <= '0;
      rsp.success      <= 1'b0;
      rsp.slots_free   <= cnt_wide[8:0];
    end else if (cmd.alloc_finish) begin
      rsp.granted_slot <= grant_wide[7:0];
      rsp.byte_offset  <= offset_wide[15:0];
      rsp.success      <= 1'b1;
      rsp.slots_free   <= cnt_dec_wide[8:0];
    end
  end

endmodule

// ----- src/fixed_block_free_list_allocator.sv -----
// Free-list allocator for one pool of CAPACITY equal-size slots. Each item on
// req is an allocate or a release; each yields exactly one item on rsp with
// the granted slot, its byte offset (slot times the element size rounded up to
// a multiple of 8, at least 8) and the free count. A release or an allocate on
// an empty pool loads the result register directly; a successful allocate
// first passes through ALLOC, as the next head comes from a registered read of
// the link memory at the old head. The result register admits a new item as soon
// as the previous result is taken. After reset a pass over all CAPACITY entries
// chains the link memory, stalling req; cfg element size writes are taken anytime.
module fixed_block_free_list_allocator
  import fbfl_pkg::*;
#(
  parameter int CAPACITY = 256
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_write,
  input  logic [8:0] cfg_data,
  input  logic       req_valid,
  output logic       req_stall,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_stall,
  output rsp_t       rsp
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  fbfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_cmd   (req.cmd),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fbfl_dpath #(
    .CAPACITY (CAPACITY)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .sts       (sts),
    .rsp       (rsp)
  );

  // A pop is only started on a non-empty list, and completes in the next cycle.
  a_alloc_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_start |-> sts.head_valid)
    else $error("allocate started on an empty free list");

  a_alloc_finish: assert property (@(posedge clk) disable iff (rst)
    cmd.alloc_start |=> cmd.alloc_finish)
    else $error("allocate did not complete one cycle after the link read");

  // A new result never overwrites one that is still waiting to be taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (cmd.release_en || cmd.alloc_fail || cmd.alloc_finish) |-> !(rsp_valid && rsp_stall))
    else $error("result register overwritten while stalled");

endmodule
